[sv/hpa_pkg.sv]
// hpa_pkg: shared types and constants for the HSL pixel adjust unit.
// Used by every module of the block except hpa_div; depends on nothing.
`default_nettype none

package hpa_pkg;

	// Divider sizes
	localparam int NUM_W     = 16;
	localparam int SAT_DEN_W = 9;
	localparam int HUE_DEN_W = 8;

	// Color math constants
	localparam int HUE_FULL  = 360;
	localparam int HUE_MOD   = 361;
	localparam int LUM_HALF  = 128;
	localparam int SUM_FULL  = 512;
	localparam int HUE_G_OFF = 120;
	localparam int HUE_B_OFF = 240;
	localparam int RECIP_45  = 1456;   // floor(2^16 / 45)
	localparam int DIV_45    = 45;

	// Configuration register indexes
	localparam logic [1:0] REG_HUE   = 2'd0;
	localparam logic [1:0] REG_SAT   = 2'd1;
	localparam logic [1:0] REG_LIGHT = 2'd2;

	// Segment of the hue circle a channel falls in
	typedef enum logic [1:0] {
		SEG_UP,
		SEG_HIGH,
		SEG_DOWN,
		SEG_LOW
	} hpa_seg_t;

	// Data that rides along the hue divider
	typedef struct packed {
		logic [7:0] alpha;
		logic       last;
		logic [7:0] lum;
		logic       grey;
		logic       hue_neg;
		logic [8:0] hue_off;
	} hpa_side_t;

	// Classified item passed from front to back through the queue
	typedef struct packed {
		hpa_side_t            side;
		logic                 sat_zero;
		logic [NUM_W-1:0]     sat_num;
		logic [SAT_DEN_W-1:0] sat_den;
		logic [NUM_W-1:0]     hue_num;
		logic [HUE_DEN_W-1:0] hue_den;
	} hpa_item_t;

endpackage

`default_nettype wire

[sv/hpa_div.sv]
// hpa_div: pipelined restoring divider, one quotient bit per stage.
// Uses no package; carries a sideband word alongside the operands.
`default_nettype none

module hpa_div #(
	parameter int NUM_W  = 16,
	parameter int DEN_W  = 8,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_v,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side,
	output logic                   out_v,
	output logic [NUM_W-1:0]       quo,
	output logic [SIDE_W-1:0]      side_out
);

	logic [NUM_W-1:0]  num_q  [1:NUM_W];
	logic [NUM_W-1:0]  quo_q  [1:NUM_W];
	logic [DEN_W-1:0]  rem_q  [1:NUM_W];
	logic [DEN_W-1:0]  den_q  [1:NUM_W];
	logic [SIDE_W-1:0] side_q [1:NUM_W];
	logic              v_q    [1:NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [NUM_W-1:0]  cur_num;
		logic [NUM_W-1:0]  cur_quo;
		logic [DEN_W-1:0]  cur_rem;
		logic [DEN_W-1:0]  cur_den;
		logic [SIDE_W-1:0] cur_side;
		logic              cur_v;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_num  = num;
			assign cur_quo  = '0;
			assign cur_rem  = '0;
			assign cur_den  = den;
			assign cur_side = side;
			assign cur_v    = in_v;
		end else begin : g_next
			assign cur_num  = num_q[k];
			assign cur_quo  = quo_q[k];
			assign cur_rem  = rem_q[k];
			assign cur_den  = den_q[k];
			assign cur_side = side_q[k];
			assign cur_v    = v_q[k];
		end

		// trial subtract of the shifted remainder
		assign trial = {cur_rem, cur_num[NUM_W-1]};
		assign diff  = trial - {1'b0, cur_den};
		assign ge    = (trial >= {1'b0, cur_den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k+1]  <= {cur_num[NUM_W-2:0], 1'b0};
				quo_q[k+1]  <= {cur_quo[NUM_W-2:0], ge};
				rem_q[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				den_q[k+1]  <= cur_den;
				side_q[k+1] <= cur_side;
			end
		end
	end

	assign out_v    = v_q[NUM_W];
	assign quo      = quo_q[NUM_W];
	assign side_out = side_q[NUM_W];

endmodule

`default_nettype wire

[sv/hpa_front.sv]
// hpa_front: accepts pixels, finds max/min and builds divider operands.
// Depends on hpa_pkg for the item type and constants.
`default_nettype none

module hpa_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [31:0]       pixel_in,
	input  wire logic              last_in,
	input  wire logic              q_full,
	output logic                   push,
	output hpa_pkg::hpa_item_t     item
);

	logic              en;
	logic              v_s1, v_s2;
	logic [7:0]        mx_s1, mn_s1, alpha_s1;
	logic              last_s1;
	logic signed [8:0] diff_s1;
	logic [8:0]        off_s1;
	hpa_pkg::hpa_item_t item_s2;

	logic [7:0]        r_c, g_c, b_c, rg_mx, rg_mn, mx_c, mn_c;
	logic signed [8:0] diff_c;
	logic [8:0]        off_c;

	// Pipeline advances unless the classified item is blocked by a full queue
	assign en       = !(v_s2 && q_full);
	assign in_stall = !en;
	assign push     = v_s2 && !q_full;
	assign item     = item_s2;

	// Stage 1: max, min and the channel difference for the hue sector
	always_comb begin
		r_c    = pixel_in[7:0];
		g_c    = pixel_in[15:8];
		b_c    = pixel_in[23:16];
		rg_mx  = (r_c > g_c) ? r_c : g_c;
		rg_mn  = (r_c < g_c) ? r_c : g_c;
		mx_c   = (b_c > rg_mx) ? b_c : rg_mx;
		mn_c   = (b_c < rg_mn) ? b_c : rg_mn;
		priority if (mx_c == r_c) begin
			diff_c = $signed({1'b0, g_c}) - $signed({1'b0, b_c});
			off_c  = 9'd0;
		end else if (mx_c == g_c) begin
			diff_c = $signed({1'b0, b_c}) - $signed({1'b0, r_c});
			off_c  = 9'(hpa_pkg::HUE_G_OFF);
		end else begin
			diff_c = $signed({1'b0, r_c}) - $signed({1'b0, g_c});
			off_c  = 9'(hpa_pkg::HUE_B_OFF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1    <= mx_c;
			mn_s1    <= mn_c;
			diff_s1  <= diff_c;
			off_s1   <= off_c;
			alpha_s1 <= pixel_in[31:24];
			last_s1  <= last_in;
		end
	end

	// Stage 2: lightness, saturation and hue divider operands
	logic [7:0]  d_c, l_c, mag_c;
	logic [8:0]  sum_c, mag9_c;
	logic [9:0]  rsum_c;
	logic [15:0] mag16_c;
	hpa_pkg::hpa_item_t item_c;

	always_comb begin
		d_c     = mx_s1 - mn_s1;
		sum_c   = {1'b0, mx_s1} + {1'b0, mn_s1};
		l_c     = sum_c[8:1];
		rsum_c  = 10'(hpa_pkg::SUM_FULL) - {1'b0, sum_c};
		mag9_c  = diff_s1[8] ? 9'(-diff_s1) : 9'(diff_s1);
		mag_c   = mag9_c[7:0];
		mag16_c = {8'd0, mag_c};

		item_c.side.alpha   = alpha_s1;
		item_c.side.last    = last_s1;
		item_c.side.lum     = l_c;
		item_c.side.grey    = (d_c == 8'd0);
		item_c.side.hue_neg = diff_s1[8];
		item_c.side.hue_off = off_s1;
		item_c.sat_zero     = (l_c == 8'd0) || (d_c == 8'd0);
		item_c.sat_num      = {d_c, 8'd0};
		item_c.sat_den      = ({1'b0, l_c} <= 9'(hpa_pkg::LUM_HALF)) ? sum_c : rsum_c[8:0];
		item_c.hue_num      = (mag16_c << 6) - (mag16_c << 2);
		item_c.hue_den      = d_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_c;
		end
	end

endmodule

`default_nettype wire

[sv/hpa_queue.sv]
// hpa_queue: short item queue between the front and back of the pixel unit.
// Depends on hpa_pkg for the item type.
`default_nettype none

module hpa_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire hpa_pkg::hpa_item_t     push_item,
	output logic                        full,
	input  wire logic                   pop,
	output logic                        valid,
	output hpa_pkg::hpa_item_t          pop_item,
	output logic [$clog2(DEPTH+1)-1:0]  count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hpa_pkg::hpa_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign valid    = (cnt_q != '0);
	assign count    = cnt_q;
	assign pop_item = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[sv/hpa_back.sv]
// hpa_back: divides, applies hue/saturation/lightness settings, converts to RGB.
// Depends on hpa_pkg and hpa_div; ends in the output register.
`default_nettype none

module hpa_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire hpa_pkg::hpa_item_t item,
	output logic                    pop,
	input  wire logic signed [9:0]  hue_ovr,
	input  wire logic signed [10:0] sat_scl,
	input  wire logic signed [10:0] lum_scl,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [31:0]             pixel_out,
	output logic                    last_out
);

	localparam logic signed [10:0] CH_OFF [3] = '{11'sd120, 11'sd0, -11'sd120};

	logic en;
	assign en  = !out_valid || !out_stall;
	assign pop = item_valid && en;

	// Dividers: hue carries the sideband, saturation carries its zero flag
	logic                        hv, sv, szero_d;
	logic [hpa_pkg::NUM_W-1:0]   hquo, squo;
	hpa_pkg::hpa_side_t          side_d;

	hpa_div #(
		.NUM_W (hpa_pkg::NUM_W),
		.DEN_W (hpa_pkg::HUE_DEN_W),
		.SIDE_W($bits(hpa_pkg::hpa_side_t))
	) u_hue_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (item_valid),
		.num     (item.hue_num),
		.den     (item.hue_den),
		.side    (item.side),
		.out_v   (hv),
		.quo     (hquo),
		.side_out(side_d)
	);

	hpa_div #(
		.NUM_W (hpa_pkg::NUM_W),
		.DEN_W (hpa_pkg::SAT_DEN_W),
		.SIDE_W(1)
	) u_sat_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (item_valid),
		.num     (item.sat_num),
		.den     (item.sat_den),
		.side    (item.sat_zero),
		.out_v   (sv),
		.quo     (squo),
		.side_out(szero_d)
	);

	// Valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			v_s1 <= hv && sv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end
	assign out_valid = v_s8;

	// Alpha and last flag ride along every stage
	logic [8:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;

	// Stage 1: hue from quotient and override, saturation clamp
	logic signed [10:0] hraw_c;
	logic [8:0]         h_c, ovu_c;
	logic [7:0]         s_c;
	logic [8:0]         h_s1;
	logic [7:0]         s_s1, l_s1;

	always_comb begin
		hraw_c = side_d.hue_neg ? $signed({2'b0, side_d.hue_off}) - $signed({4'b0, hquo[6:0]})
		                        : $signed({2'b0, side_d.hue_off}) + $signed({4'b0, hquo[6:0]});
		if (side_d.grey) begin
			hraw_c = '0;
		end
		if (hraw_c < 0) begin
			hraw_c = hraw_c + 11'sd360;
		end else if (hraw_c > 11'sd360) begin
			hraw_c = 11'sd360;
		end
		h_c   = hraw_c[8:0];
		ovu_c = hue_ovr[8:0];
		if (!hue_ovr[9]) begin
			h_c = (ovu_c > 9'(hpa_pkg::HUE_FULL)) ? ovu_c - 9'(hpa_pkg::HUE_MOD) : ovu_c;
		end
		s_c = szero_d ? 8'd0 : ((|squo[15:8]) ? 8'd255 : squo[7:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1   <= h_c;
			s_s1   <= s_c;
			l_s1   <= side_d.lum;
			tag_s1 <= {side_d.last, side_d.alpha};
		end
	end

	// Stage 2: scale products
	logic [8:0]  h_s2;
	logic [7:0]  s_s2, l_s2;
	logic [17:0] ss_s2, ls_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			h_s2   <= h_s1;
			s_s2   <= s_s1;
			l_s2   <= l_s1;
			ss_s2  <= s_s1 * sat_scl[9:0];
			ls_s2  <= l_s1 * lum_scl[9:0];
			tag_s2 <= tag_s1;
		end
	end

	// Stage 3: select scaled or original, saturate at 255
	logic [8:0] h_s3;
	logic [7:0] s_s3, l_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			h_s3   <= h_s2;
			s_s3   <= sat_scl[10] ? s_s2 : ((|ss_s2[17:16]) ? 8'd255 : ss_s2[15:8]);
			l_s3   <= lum_scl[10] ? l_s2 : ((|ls_s2[17:16]) ? 8'd255 : ls_s2[15:8]);
			tag_s3 <= tag_s2;
		end
	end

	// Stage 4: l * s
	logic [8:0]  h_s4;
	logic [7:0]  s_s4, l_s4;
	logic [15:0] lsp_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			h_s4   <= h_s3;
			s_s4   <= s_s3;
			l_s4   <= l_s3;
			lsp_s4 <= l_s3 * s_s3;
			tag_s4 <= tag_s3;
		end
	end

	// Stage 5: q, p, ramp height and per channel segment and ramp factor
	logic [7:0]         m_c;
	logic [9:0]         q_c;
	logic [8:0]         dq_c;
	logic signed [10:0] p_c;
	logic [9:0]         q_s5, q_s6, q_s7;
	logic [8:0]         dq_s5;
	logic signed [10:0] p_s5, p_s6, p_s7;
	logic [7:0]         l_s5, l_s6, l_s7;
	logic               sz_s5, sz_s6, sz_s7;

	always_comb begin
		m_c = lsp_s4[15:8];
		if ({1'b0, l_s4} < 9'(hpa_pkg::LUM_HALF)) begin
			q_c  = {2'b0, l_s4} + {2'b0, m_c};
			dq_c = {m_c, 1'b0};
		end else begin
			q_c  = {2'b0, l_s4} + {2'b0, s_s4} - {2'b0, m_c};
			dq_c = {s_s4 - m_c, 1'b0};
		end
		p_c = $signed({2'b0, l_s4, 1'b0}) - $signed({1'b0, q_c});
	end

	hpa_pkg::hpa_seg_t seg_s5 [3];
	hpa_pkg::hpa_seg_t seg_s6 [3];
	hpa_pkg::hpa_seg_t seg_s7 [3];
	logic [8:0]        k_s5   [3];
	logic [17:0]       prod_s6[3];
	logic [14:0]       y_s7   [3];
	logic [9:0]        q0_s7  [3];
	logic [7:0]        ch_c   [3];

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic signed [10:0] t_c;
		logic [8:0]         tu_c;
		logic [10:0]        k6_c;
		hpa_pkg::hpa_seg_t  seg_c;
		logic [8:0]         k_c;
		logic [25:0]        rm_c;
		logic [15:0]        q45_c, rem_c;
		logic [9:0]         quot_c;
		logic signed [11:0] val_c;

		// Wrap the channel hue into 0..360 and pick its segment
		always_comb begin
			t_c = $signed({2'b0, h_s4}) + CH_OFF[c];
			if (t_c < 0) begin
				t_c = t_c + 11'sd360;
			end
			if (t_c > 11'sd360) begin
				t_c = t_c - 11'sd360;
			end
			tu_c = t_c[8:0];
			priority if (tu_c < 9'd60) begin
				seg_c = hpa_pkg::SEG_UP;
				k6_c  = ({2'b0, tu_c} << 2) + ({2'b0, tu_c} << 1);
			end else if (tu_c < 9'd180) begin
				seg_c = hpa_pkg::SEG_HIGH;
				k6_c  = '0;
			end else if (tu_c < 9'(hpa_pkg::HUE_B_OFF)) begin
				seg_c = hpa_pkg::SEG_DOWN;
				k6_c  = ({2'b0, 9'(hpa_pkg::HUE_B_OFF) - tu_c} << 2)
				      + ({2'b0, 9'(hpa_pkg::HUE_B_OFF) - tu_c} << 1);
			end else begin
				seg_c = hpa_pkg::SEG_LOW;
				k6_c  = '0;
			end
			k_c = k6_c[8:0];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				seg_s5[c]  <= seg_c;
				k_s5[c]    <= k_c;
				// Stage 6: ramp product
				seg_s6[c]  <= seg_s5[c];
				prod_s6[c] <= dq_s5 * k_s5[c];
				// Stage 7: divide by 360 as /8 then reciprocal of 45
				seg_s7[c]  <= seg_s6[c];
				y_s7[c]    <= prod_s6[c][17:3];
				q0_s7[c]   <= rm_c[25:16];
			end
		end

		assign rm_c = prod_s6[c][17:3] * 11'(hpa_pkg::RECIP_45);

		// Stage 8: correct the quotient, add p, pick segment and clamp
		always_comb begin
			q45_c  = ({6'd0, q0_s7[c]} << 5) + ({6'd0, q0_s7[c]} << 3)
			       + ({6'd0, q0_s7[c]} << 2) + {6'd0, q0_s7[c]};
			rem_c  = {1'b0, y_s7[c]} - q45_c;
			quot_c = q0_s7[c] + ((rem_c >= 16'(hpa_pkg::DIV_45)) ? 10'd1 : 10'd0);
			unique case (seg_s7[c])
				hpa_pkg::SEG_UP,
				hpa_pkg::SEG_DOWN: val_c = 12'(p_s7) + $signed({2'b0, quot_c});
				hpa_pkg::SEG_HIGH: val_c = $signed({2'b0, q_s7});
				hpa_pkg::SEG_LOW:  val_c = 12'(p_s7);
				default:           val_c = 12'(p_s7);
			endcase
			if (sz_s7) begin
				ch_c[c] = l_s7;
			end else if (val_c < 0) begin
				ch_c[c] = 8'd0;
			end else if (val_c > 12'sd255) begin
				ch_c[c] = 8'd255;
			end else begin
				ch_c[c] = val_c[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s5   <= q_c;
			dq_s5  <= dq_c;
			p_s5   <= p_c;
			l_s5   <= l_s4;
			sz_s5  <= (s_s4 == 8'd0);
			tag_s5 <= tag_s4;
			q_s6   <= q_s5;
			p_s6   <= p_s5;
			l_s6   <= l_s5;
			sz_s6  <= sz_s5;
			tag_s6 <= tag_s5;
			q_s7   <= q_s6;
			p_s7   <= p_s6;
			l_s7   <= l_s6;
			sz_s7  <= sz_s6;
			tag_s7 <= tag_s6;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			pixel_out <= {tag_s7[7:0], ch_c[2], ch_c[1], ch_c[0]};
			last_out  <= tag_s7[8];
		end
	end

endmodule

`default_nettype wire

[sv/hsl_pixel_adjust_unit.sv]
// hsl_pixel_adjust_unit: top level of the HSL pixel adjust block.
// Depends on hpa_pkg, hpa_front, hpa_queue, hpa_back (and hpa_div below it).
//
// Usage:
//   Input channel (in_valid / in_stall): one 32-bit pixel (red low byte, then
//   green, blue, alpha) plus a last flag per item. Output channel (out_valid /
//   out_stall) returns the adjusted pixel with alpha and last copied.
//   Config channel (cfg_valid / cfg_ready, always ready): cfg_index 0 sets the
//   hue override, 1 the saturation scale, 2 the lightness scale; index 3 is
//   ignored. Negative values leave the component alone. Write only when idle.
//   Throughput: one item per cycle while out_stall is low; the front, queue
//   and a 24-stage back end are all fully pipelined, the back end being two
//   16-stage radix-2 dividers followed by eight stages of scaling and RGB
//   rebuild.
//   Reset: the config registers go to -1 and every pipeline and the queue empty.
//   When the receiver stalls, the back end freezes in place, the queue fills,
//   and then the front raises in_stall.
`default_nettype none

module hsl_pixel_adjust_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] pixel_in,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pixel_out,
	output logic             last_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration registers
	logic signed [9:0]  hue_ovr_q;
	logic signed [10:0] sat_scl_q, lum_scl_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_ovr_q <= '1;
			sat_scl_q <= '1;
			lum_scl_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hpa_pkg::REG_HUE:   hue_ovr_q <= cfg_data[9:0];
				hpa_pkg::REG_SAT:   sat_scl_q <= cfg_data;
				hpa_pkg::REG_LIGHT: lum_scl_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Front, queue, back
	logic               push, q_full, q_valid, q_pop;
	hpa_pkg::hpa_item_t f_item, q_item;
	logic [CNT_W-1:0]   q_cnt;

	hpa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_in(pixel_in),
		.last_in (last_in),
		.q_full  (q_full),
		.push    (push),
		.item    (f_item)
	);

	hpa_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(f_item),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_item (q_item),
		.count    (q_cnt)
	);

	hpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(q_valid),
		.item      (q_item),
		.pop       (q_pop),
		.hue_ovr   (hue_ovr_q),
		.sat_scl   (sat_scl_q),
		.lum_scl   (lum_scl_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.last_out  (last_out)
	);

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("input stalled while queue has room");

	a_back_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !q_pop)
		else $error("queue popped while back end is frozen");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> q_cnt == $past(q_cnt) + CNT_W'($past(push)) - CNT_W'($past(q_pop)))
		else $error("queue count out of step with push and pop");

endmodule

`default_nettype wire
